[rtl/ebl_pkg.sv]
// ebl_pkg: shared types, register indexes and reset constants for the
// exponential backoff limiter; used by every module under rtl
`default_nettype none

package ebl_pkg;

    localparam int unsigned TIME_W  = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_LIMITED = 2'd1,
        MODE_SUCCESS = 2'd2,
        MODE_QUERY   = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_CAP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DURATION  = 2'd2;

    localparam logic [TIME_W-1:0]  RST_BACKOFF_CAP     = 16'd600;
    localparam logic [COUNT_W-1:0] RST_BLOCK_THRESHOLD = 8'd5;
    localparam logic [TIME_W-1:0]  RST_BLOCK_DURATION  = 16'd3600;
    localparam logic [TIME_W-1:0]  RST_BACKOFF_LEN     = 16'd1;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0]  backoff_cap;
        logic [COUNT_W-1:0] block_threshold;
        logic [TIME_W-1:0]  block_duration;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  backoff_len;
        logic [COUNT_W-1:0] consecutive;
        logic               backoff_active;
        logic [TIME_W-1:0]  elapsed;
        logic               block_flag;
        logic [TIME_W-1:0]  block_left;
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]  wait_seconds;
        logic               blocked;
        logic [COUNT_W-1:0] limit_count;
    } t_result;

endpackage

`default_nettype wire

[rtl/ebl_cfg.sv]
// ebl_cfg: configuration register file written through a plain write port
// depends on ebl_pkg for register indexes and reset values
`default_nettype none

module ebl_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ebl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ebl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ebl_pkg::t_cfg                        o_cfg
);

    ebl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backoff_cap     <= ebl_pkg::RST_BACKOFF_CAP;
            r_cfg.block_threshold <= ebl_pkg::RST_BLOCK_THRESHOLD;
            r_cfg.block_duration  <= ebl_pkg::RST_BLOCK_DURATION;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ebl_pkg::CFG_BACKOFF_CAP: begin
                    r_cfg.backoff_cap <= i_cfg_data;
                end
                ebl_pkg::CFG_BLOCK_THRESHOLD: begin
                    r_cfg.block_threshold <= i_cfg_data[ebl_pkg::COUNT_W-1:0];
                end
                ebl_pkg::CFG_BLOCK_DURATION: begin
                    r_cfg.block_duration <= i_cfg_data;
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/ebl_step.sv]
// ebl_step: combinational state update and result for one item
// depends on ebl_pkg for mode codes, state, config and result types
`default_nettype none

module ebl_step (
    input  wire ebl_pkg::t_mode                i_mode,
    input  wire logic [ebl_pkg::TIME_W-1:0]    i_retry_after,
    input  wire ebl_pkg::t_cfg                 i_cfg,
    input  wire ebl_pkg::t_state               i_state,
    output ebl_pkg::t_state                    o_state,
    output ebl_pkg::t_result                   o_result
);

    ebl_pkg::t_state        s;
    logic [ebl_pkg::TIME_W:0] dbl;

    assign dbl = {i_state.backoff_len, 1'b0};

    always_comb begin
        s = i_state;
        unique case (i_mode)
            ebl_pkg::MODE_TICK: begin
                if (s.backoff_active && (s.elapsed != ebl_pkg::TIME_MAX)) begin
                    s.elapsed = s.elapsed + 1'b1;
                end
                if (s.block_flag && (s.block_left != '0)) begin
                    s.block_left = s.block_left - 1'b1;
                end
            end
            ebl_pkg::MODE_LIMITED: begin
                s.elapsed        = '0;
                s.backoff_active = 1'b1;
                if (s.consecutive != ebl_pkg::COUNT_MAX) begin
                    s.consecutive = s.consecutive + 1'b1;
                end
                if (i_retry_after != '0) begin
                    s.backoff_len = i_retry_after;
                end else if (dbl < {1'b0, i_cfg.backoff_cap}) begin
                    s.backoff_len = dbl[ebl_pkg::TIME_W-1:0];
                end else begin
                    s.backoff_len = i_cfg.backoff_cap;
                end
                if (s.consecutive >= i_cfg.block_threshold) begin
                    s.block_flag = 1'b1;
                    s.block_left = i_cfg.block_duration;
                end
            end
            ebl_pkg::MODE_SUCCESS: begin
                if (s.consecutive != '0) begin
                    s.consecutive = s.consecutive - 1'b1;
                end
                if (s.consecutive == '0) begin
                    s.backoff_len    = ebl_pkg::RST_BACKOFF_LEN;
                    s.backoff_active = 1'b0;
                    s.elapsed        = '0;
                end
            end
            ebl_pkg::MODE_QUERY: begin
                // report only
            end
            default: begin
            end
        endcase

        // expired block clears on the item that sees it at zero
        if (s.block_flag && (s.block_left == '0)) begin
            s.block_flag = 1'b0;
        end
    end

    always_comb begin
        o_result.limit_count  = s.consecutive;
        o_result.blocked      = s.block_flag;
        o_result.wait_seconds = '0;
        if (s.block_flag) begin
            o_result.wait_seconds = s.block_left;
        end else if (s.backoff_active && (s.elapsed < s.backoff_len)) begin
            o_result.wait_seconds = s.backoff_len - s.elapsed;
        end
    end

    assign o_state = s;

endmodule

`default_nettype wire

[rtl/exponential_backoff_limiter_unit.sv]
// exponential_backoff_limiter_unit: top level, input register, state and
// result register; depends on ebl_pkg, ebl_cfg and ebl_step
//
//   channel   direction  signals                                   transfer when
//   in        input      i_in_valid o_in_stall i_mode i_retry_after  valid & !stall
//   out       output     o_out_valid i_out_stall o_wait_seconds
//                        o_blocked o_limit_count                   valid & !stall
//   cfg       input      i_cfg_we i_cfg_index i_cfg_data            i_cfg_we
//
// one item per cycle sustained while the output is not stalled; each item passes from the
// input register into the result register, from which its result transfers out
// synchronous active-low reset restores register defaults and limiter state
// a stalled output holds the result and the input register; o_in_stall rises
// only when both stages are full and the output is stalled
`default_nettype none

module exponential_backoff_limiter_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [ebl_pkg::TIME_W-1:0]      i_retry_after,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [ebl_pkg::TIME_W-1:0]           o_wait_seconds,
    output logic                                 o_blocked,
    output logic [ebl_pkg::COUNT_W-1:0]          o_limit_count,
    input  wire logic                            i_cfg_we,
    input  wire logic [ebl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ebl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    ebl_pkg::t_cfg    cfg;
    ebl_pkg::t_state  r_state;
    ebl_pkg::t_state  n_state;
    ebl_pkg::t_result n_result;
    ebl_pkg::t_result r_result;

    logic                         r_in_valid;
    ebl_pkg::t_mode               r_mode;
    logic [ebl_pkg::TIME_W-1:0]   r_retry;
    logic                         r_out_valid;
    logic                         out_free;
    logic                         advance;
    logic                         in_take;

    ebl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ebl_step u_step (
        .i_mode        (r_mode),
        .i_retry_after (r_retry),
        .i_cfg         (cfg),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode  <= ebl_pkg::t_mode'(i_mode);
            r_retry <= i_retry_after;
        end
    end

    // limiter state commits when its item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.backoff_len    <= ebl_pkg::RST_BACKOFF_LEN;
            r_state.consecutive    <= '0;
            r_state.backoff_active <= 1'b0;
            r_state.elapsed        <= '0;
            r_state.block_flag     <= 1'b0;
            r_state.block_left     <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_wait_seconds = r_result.wait_seconds;
    assign o_blocked      = r_result.blocked;
    assign o_limit_count  = r_result.limit_count;

endmodule

`default_nettype wire
